>>> src/khcc_pkg.sv
// Package with shared constants for the key hash collision checker.
`default_nettype none
package khcc_pkg;
  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] LEN_MASK = 32'hf4000000;
  localparam logic [1:0] REG_FUNC_WORD = 2'd0;
  localparam logic [1:0] REG_TABLE_BITS = 2'd1;
endpackage
`default_nettype wire

>>> src/key_hash_with_collision_check.sv
// Top level of the key hash collision checker.
`default_nettype none
// Key bytes arrive one beat at a time; a zero byte ends a key and yields one result beat
// holding the key's hash, whether an equal hash was already in the bucket table, and the
// sticky collision flag. A nonzero byte updates the FNV hash and the samples. At a key
// end the hash is formed, then the bucket table is probed one bucket at a time (memory
// read, then compare and write back), up to 2^bits+8 probes. new_set starts a clearing pass
// over all 2^MAX_TABLE_BITS used bits before that byte is processed; a word write
// recomputes the FNV seed from the four bytes of the word. After reset the block runs the
// same clearing pass and then the seed computation before it takes its first beat. Input is
// not taken in a cycle that writes a register. Stored hashes stay undefined until written.
module key_hash_with_collision_check #(
  parameter int MAX_TABLE_BITS = 12
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // key_byte
  input  wire         in_tuser,   // new_set
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // key_hash[31:0], key_collides, any_collision, zero pad
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int TB = MAX_TABLE_BITS;
  localparam int DEPTH = 1 << TB;
  localparam int PW = TB + 2;

  localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_HASH = 3'd2, S_RD = 3'd3,
                         S_CMP = 3'd4, S_OUT = 3'd5, S_SEED = 3'd6;

  logic [2:0] st_r;
  logic [31:0] word_r, seed_r, fnv_r, len_r, hash_r, perturb_r, j_r;
  logic [3:0] tbits_r;
  logic [7:0] samp_r [3];
  logic [1:0] seed_cnt_r;
  logic [TB-1:0] clr_r;
  logic [PW-1:0] iter_r;
  logic [7:0] byte_r;
  logic any_r, hit_r, pend_r;

  logic used_mem [DEPTH];
  logic [31:0] hash_mem [DEPTH];
  logic used_q;
  logic [31:0] hash_q;
  logic [TB-1:0] idx_r;

  // Registers sit at byte addresses 0 and 4, so bit 2 selects the register.
  logic cfg_wr;
  logic [1:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx = {1'b0, cfg_paddr[2]};
  always_comb begin
    case (cfg_idx)
      khcc_pkg::REG_FUNC_WORD: cfg_prdata = word_r;
      khcc_pkg::REG_TABLE_BITS: cfg_prdata = {28'd0, tbits_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  // Effective bucket bits, clamped to 1..TB.
  logic [4:0] bits_eff;
  logic [PW-1:0] nb, lim;
  logic [TB-1:0] mask;
  always_comb begin
    bits_eff = (tbits_r == 4'd0) ? 5'd1 : {1'b0, tbits_r};
    if (int'(bits_eff) > TB) bits_eff = 5'(TB);
    nb = PW'(1) << bits_eff;
    lim = nb + PW'(8);
    mask = TB'(nb - PW'(1));
  end

  function automatic logic [31:0] sx(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  logic [31:0] ln, a, b, c, hnew;
  always_comb begin
    ln = |(word_r & khcc_pkg::LEN_MASK) ? len_r : 32'd0;
    a = sx(samp_r[0]); b = sx(samp_r[1]); c = sx(samp_r[2]);
    if (word_r[31:24] > 8'h0f) hnew = fnv_r;
    else begin
      case (word_r[27:24])
        4'h1, 4'h9: hnew = a;
        4'h2: hnew = a + b;
        4'h3: hnew = a + b + c;
        4'h4, 4'hc: hnew = ln;
        4'h5: hnew = ln + a;
        4'h6: hnew = ln + a + b;
        4'h7: hnew = ln + a + b + c;
        4'ha: hnew = (a << 8) | b;
        4'hb: hnew = (a << 16) | (b << 8) | c;
        4'hd: hnew = (ln << 8) | a;
        4'he: hnew = (ln << 16) | (a << 8) | b;
        4'hf: hnew = (ln << 24) | (a << 16) | (b << 8) | c;
        default: hnew = 32'd0;
      endcase
    end
  end

  logic [31:0] jn;
  assign jn = j_r * 32'd5 + 32'd1 + perturb_r;

  assign in_tready = (st_r == S_IDLE) && !cfg_wr;
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {6'd0, any_r, hit_r, hash_r};

  logic mem_we, mem_wu;
  logic [TB-1:0] mem_wa;
  logic [31:0] mem_wd;
  always_comb begin
    mem_we = 1'b0; mem_wu = 1'b0; mem_wa = idx_r; mem_wd = hash_r;
    if (st_r == S_CLR) begin
      mem_we = 1'b1; mem_wa = clr_r;
    end else if (st_r == S_CMP && !used_q) begin
      mem_we = 1'b1; mem_wu = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) used_mem[mem_wa] <= mem_wu;
    if (mem_we && mem_wu) hash_mem[mem_wa] <= mem_wd;
    used_q <= used_mem[idx_r];
    hash_q <= hash_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; word_r <= 32'd0; tbits_r <= 4'd1; any_r <= 1'b0;
      seed_r <= khcc_pkg::FNV_BASIS; seed_cnt_r <= 2'd0; len_r <= 32'd0;
      fnv_r <= 32'd0; samp_r <= '{8'd0, 8'd0, 8'd0}; pend_r <= 1'b0;
      clr_r <= '0; iter_r <= '0; hit_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_idx == khcc_pkg::REG_TABLE_BITS) tbits_r <= cfg_pwdata[3:0];
      if (cfg_wr && cfg_idx == khcc_pkg::REG_FUNC_WORD) begin
        word_r <= cfg_pwdata; seed_r <= khcc_pkg::FNV_BASIS; seed_cnt_r <= 2'd0;
        // A running clearing pass finishes first and then computes the seed.
        if (st_r == S_CLR) pend_r <= 1'b0;
        else st_r <= S_SEED;
      end else begin
        case (st_r)
          S_SEED: begin
            seed_r <= (seed_r ^ {24'd0, word_r[8*seed_cnt_r +: 8]}) * khcc_pkg::FNV_PRIME;
            seed_cnt_r <= seed_cnt_r + 2'd1;
            if (seed_cnt_r == 2'd3) begin
              st_r <= S_IDLE;
              fnv_r <= (seed_r ^ {24'd0, word_r[31:24]}) * khcc_pkg::FNV_PRIME;
              len_r <= 32'd0; samp_r <= '{8'd0, 8'd0, 8'd0};
            end
          end
          S_IDLE: if (in_tvalid && in_tready) begin
            byte_r <= in_tdata;
            if (in_tuser) begin
              any_r <= 1'b0; clr_r <= '0; st_r <= S_CLR; pend_r <= 1'b1;
            end else pend_r <= 1'b0;
            if (!in_tuser) begin
              if (in_tdata != 8'd0) begin
                fnv_r <= (fnv_r ^ {24'd0, in_tdata}) * khcc_pkg::FNV_PRIME;
                for (int s = 0; s < 3; s++)
                  if ({24'd0, word_r[16-8*s +: 8]} == len_r) samp_r[s] <= in_tdata;
                if (len_r != 32'hffffffff) len_r <= len_r + 32'd1;
              end else st_r <= S_HASH;
            end
          end
          S_CLR: begin
            clr_r <= clr_r + TB'(1);
            if (clr_r == TB'(DEPTH - 1)) begin
              // Without a waiting byte (after reset or a word write) the seed follows.
              if (!pend_r) st_r <= S_SEED;
              else if (byte_r != 8'd0) begin
                fnv_r <= (fnv_r ^ {24'd0, byte_r}) * khcc_pkg::FNV_PRIME;
                for (int s = 0; s < 3; s++)
                  if ({24'd0, word_r[16-8*s +: 8]} == len_r) samp_r[s] <= byte_r;
                if (len_r != 32'hffffffff) len_r <= len_r + 32'd1;
                st_r <= S_IDLE;
              end else st_r <= S_HASH;
            end
          end
          S_HASH: begin
            hash_r <= hnew; iter_r <= '0;
            st_r <= S_RD; hit_r <= 1'b0;
            idx_r <= TB'(32'd1 + hnew) & mask;
            j_r <= 32'd1 + hnew; perturb_r <= hnew >> 5;
          end
          S_RD: st_r <= S_CMP;
          S_CMP: begin
            if (!used_q) st_r <= S_OUT;
            else if (hash_q == hash_r) begin
              hit_r <= 1'b1; any_r <= 1'b1; st_r <= S_OUT;
            end else if (iter_r + PW'(1) >= lim) st_r <= S_OUT;
            else begin
              iter_r <= iter_r + PW'(1);
              j_r <= jn; perturb_r <= perturb_r >> 5;
              idx_r <= TB'(jn) & mask; st_r <= S_RD;
            end
          end
          S_OUT: if (out_tready) begin
            st_r <= S_IDLE; fnv_r <= seed_r; len_r <= 32'd0;
            samp_r <= '{8'd0, 8'd0, 8'd0};
          end
          default: st_r <= S_IDLE;
        endcase
      end
    end
  end

  // A collision report must also show up in the sticky flag.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_tvalid && out_tdata[32] |-> out_tdata[33])
    else $error("collision without sticky flag");
  // Input is never taken while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready)
    else $error("input accepted during result");
  // Probe count stays within the limit.
  assert property (@(posedge clk) disable iff (!rst_n) st_r == S_CMP |-> iter_r < lim)
    else $error("probe overrun");
endmodule
`default_nettype wire
